>>> sv/dnsrap_pkg.sv
// Shared types and constants for the DNS response address parser.
package dnsrap_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int FIXED_LEN = 10;      // type, class, ttl, rdata length
  localparam int QUESTION_TAIL = 4;   // qtype, qclass

  localparam logic [7:0]  POINTER_MARK = 8'hC0;
  localparam logic [15:0] ADDR_TYPE = 16'd1;
  localparam logic [15:0] ADDR_LEN = 16'd4;
  localparam logic [15:0] EXPECTED_ID_RST = 16'h5412;

  typedef enum logic [2:0] {
    ST_RESOLVED    = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_ID_MISMATCH = 3'd2,
    ST_NO_ANSWERS  = 3'd3,
    ST_NO_ADDRESS  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
  } result_t;

endpackage

>>> sv/dns_response_address_parser_unit.sv
// DNS response address parser: one payload byte per clock cycle while the result
// register can take a final byte. Each byte transaction passes an input register, the
// header/question/answer state update and a result register; a payload's result is
// registered when its final byte (tlast) leaves the input register. Exactly one result
// transaction per payload. The expected query id resets to 0x5412; the user must write it
// through cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce this.
module dns_response_address_parser_unit
  import dnsrap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // expected_id
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // [2:0] status, [34:3] address, [39:35] zero
);

  logic [15:0] expected_id_r;
  logic        item_valid;
  item_t       item;
  logic        take;
  logic        push;
  logic        out_free;
  result_t     result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= EXPECTED_ID_RST;
    end else if (cfg_wr_en) begin
      expected_id_r <= cfg_wr_data;
    end
  end

  dnsrap_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dnsrap_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .expected_id (expected_id_r),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .take        (take),
    .push        (push),
    .result      (result)
  );

  dnsrap_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> sv/dnsrap_in_reg.sv
// Input register stage holding one payload byte transaction.
module dnsrap_in_reg
  import dnsrap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r.data <= in_tdata;
      item_r.last <= in_tlast;
    end
  end

endmodule

>>> sv/dnsrap_parse.sv
// Per-byte parse state machine: header, questions, answer records.
module dnsrap_parse
  import dnsrap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] expected_id,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        out_free,
  output logic        take,
  output logic        push,
  output result_t     result
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QFIXED = 3'd2,
    PH_ANAME  = 3'd3,
    PH_AFIXED = 3'd4,
    PH_RDATA  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [15:0] aleft_r, aleft_nxt;
  logic [15:0] seen_id_r, seen_id_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rdlen_r, rdlen_nxt;
  logic [31:0] acc_r, acc_nxt;
  status_t     outcome_r, outcome_nxt;

  logic [7:0]  b;
  logic [15:0] skip_dec;
  logic [15:0] aleft_dec;
  logic        is_ptr;
  logic        capture;

  // a final byte can only be consumed when the result register has room
  assign take = item_valid && (!item.last || out_free);
  assign push = take && item.last;

  assign b         = item.data;
  assign skip_dec  = skip_r - 16'(skip_r != 16'd0);
  assign aleft_dec = aleft_r - 16'd1;
  assign is_ptr    = (b & POINTER_MARK) == POINTER_MARK;
  assign capture   = (rtype_r == ADDR_TYPE) && (rdlen_r == ADDR_LEN);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    qleft_nxt   = qleft_r;
    aleft_nxt   = aleft_r;
    seen_id_nxt = seen_id_r;
    rtype_nxt   = rtype_r;
    rdlen_nxt   = rdlen_r;
    acc_nxt     = acc_r;
    outcome_nxt = outcome_r;
    result      = '{status: ST_RESOLVED, address: 32'd0};

    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == 4'd0 || pos_r == 4'd1) seen_id_nxt = {seen_id_r[7:0], b};
          if (pos_r == 4'd4 || pos_r == 4'd5) qleft_nxt = {qleft_r[7:0], b};
          if (pos_r == 4'd6 || pos_r == 4'd7) aleft_nxt = {aleft_r[7:0], b};
          if (pos_r >= 4'(HEADER_BYTES - 1)) begin
            pos_nxt  = 4'd0;
            skip_nxt = 16'd0;
            if (seen_id_nxt != expected_id) begin
              outcome_nxt = ST_ID_MISMATCH;
              phase_nxt   = PH_DONE;
            end else if (aleft_nxt == 16'd0) begin
              outcome_nxt = ST_NO_ANSWERS;
              phase_nxt   = PH_DONE;
            end else begin
              outcome_nxt = ST_NO_ADDRESS;
              phase_nxt   = (qleft_nxt == 16'd0) ? PH_ANAME : PH_QNAME;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (skip_r != 16'd0) begin
            skip_nxt = skip_dec;
          end else if (b == 8'd0 || is_ptr) begin
            // end of name; a pointer carries one more byte
            if (phase_r == PH_QNAME) begin
              phase_nxt = PH_QFIXED;
              skip_nxt  = 16'(QUESTION_TAIL) + 16'(is_ptr);
            end else begin
              phase_nxt = PH_AFIXED;
              pos_nxt   = 4'd0;
              skip_nxt  = 16'(is_ptr);
            end
          end else begin
            skip_nxt = {8'd0, b};
          end
        end
        PH_QFIXED: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            qleft_nxt = qleft_r - 16'd1;
            phase_nxt = (qleft_nxt == 16'd0) ? PH_ANAME : PH_QNAME;
          end
        end
        PH_AFIXED: begin
          if (skip_r != 16'd0) begin
            skip_nxt = skip_dec;
          end else begin
            if (pos_r == 4'd0 || pos_r == 4'd1) rtype_nxt = {rtype_r[7:0], b};
            if (pos_r == 4'd8 || pos_r == 4'd9) rdlen_nxt = {rdlen_r[7:0], b};
            if (pos_r >= 4'(FIXED_LEN - 1)) begin
              pos_nxt = 4'd0;
              if (rdlen_nxt == 16'd0) begin
                aleft_nxt = aleft_dec;
                skip_nxt  = 16'd0;
                phase_nxt = (aleft_dec == 16'd0) ? PH_DONE : PH_ANAME;
              end else begin
                phase_nxt = PH_RDATA;
                skip_nxt  = rdlen_nxt;
                acc_nxt   = 32'd0;
              end
            end else begin
              pos_nxt = pos_r + 4'd1;
            end
          end
        end
        PH_RDATA: begin
          if (capture) acc_nxt = {acc_r[23:0], b};
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            if (capture) begin
              outcome_nxt = ST_RESOLVED;
              phase_nxt   = PH_DONE;
            end else begin
              aleft_nxt = aleft_dec;
              skip_nxt  = 16'd0;
              phase_nxt = (aleft_dec == 16'd0) ? PH_DONE : PH_ANAME;
            end
          end
        end
        default: begin
        end
      endcase

      if (item.last) begin
        result.status  = (phase_nxt == PH_HEADER) ? ST_TOO_SHORT : outcome_nxt;
        result.address = (result.status == ST_RESOLVED) ? acc_nxt : 32'd0;
        phase_nxt   = PH_HEADER;
        pos_nxt     = 4'd0;
        skip_nxt    = 16'd0;
        qleft_nxt   = 16'd0;
        aleft_nxt   = 16'd0;
        seen_id_nxt = 16'd0;
        rtype_nxt   = 16'd0;
        rdlen_nxt   = 16'd0;
        acc_nxt     = 32'd0;
        outcome_nxt = ST_RESOLVED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= 4'd0;
      skip_r    <= 16'd0;
      qleft_r   <= 16'd0;
      aleft_r   <= 16'd0;
      seen_id_r <= 16'd0;
      rtype_r   <= 16'd0;
      rdlen_r   <= 16'd0;
      acc_r     <= 32'd0;
      outcome_r <= ST_RESOLVED;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      skip_r    <= skip_nxt;
      qleft_r   <= qleft_nxt;
      aleft_r   <= aleft_nxt;
      seen_id_r <= seen_id_nxt;
      rtype_r   <= rtype_nxt;
      rdlen_r   <= rdlen_nxt;
      acc_r     <= acc_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> phase_r == PH_HEADER && pos_r == 4'd0 && skip_r == 16'd0)
    else $error("parser did not restart after final byte");

  a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> pos_r < 4'(HEADER_BYTES))
    else $error("header position out of range");

  a_fixed_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_AFIXED |-> pos_r < 4'(FIXED_LEN))
    else $error("fixed-field position out of range");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into occupied output register");

endmodule

>>> sv/dnsrap_out_reg.sv
// Result register driving the output stream.
module dnsrap_out_reg
  import dnsrap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  result_t     result,
  output logic        out_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  logic    valid_r;
  result_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, res_r.address, res_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= push;
    end
    if (push) begin
      res_r <= result;
    end
  end

  a_addr_only_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.status != ST_RESOLVED |-> res_r.address == 32'd0)
    else $error("address nonzero on unresolved status");

endmodule
